// ===== design/lsts_pkg.sv =====
// shared types, widths, constants and sensor wiring tables for the line sensor scanner
package lsts_pkg;

    // default sizing handed to the top level
    localparam int NUM_SENSORS_DEF = 16;
    localparam int SAMPLE_BITS_DEF = 10;

    // fixed field widths
    localparam int CHAN_W   = 4;
    localparam int VALUE_W  = 10;
    localparam int GAIN_W   = 10;
    localparam int OFFSET_W = 11;
    localparam int FRAC_W   = 8;
    localparam int MAP_W    = 16;
    localparam int MUX_W    = 4;
    localparam int LED_W    = 5;
    localparam int CFG_IDX_W = 1;

    // calibration and threshold reset values
    localparam int VALUE_MAX = 1023;
    localparam logic [VALUE_W-1:0] THRESH_RESET = VALUE_W'(500);
    localparam logic [GAIN_W-1:0]  GAIN_ONE     = GAIN_W'(256);

    // item commands
    typedef enum logic [0:0] {
        CMD_SAMPLE = 1'b0,
        CMD_LOAD   = 1'b1
    } t_cmd;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESH_UP   = 1'b0,
        CFG_THRESH_DOWN = 1'b1
    } t_cfg_idx;

    // converter mux channel wired to each sensor
    localparam logic [MUX_W-1:0] MUX_OF_SENSOR [16] = '{
        4'd8, 4'd9, 4'd13, 4'd11, 4'd13, 4'd11, 4'd9, 4'd8,
        4'd0, 4'd1, 4'd3,  4'd2,  4'd0,  4'd1,  4'd3, 4'd2
    };

    // charlieplex pin enables per sensor led (bit 0 ra7 .. bit 4 rc2)
    localparam logic [LED_W-1:0] LED_EN_OF_SENSOR [16] = '{
        5'd18, 5'd18, 5'd9,  5'd9,  5'd5,  5'd20, 5'd20, 5'd5,
        5'd3,  5'd6,  5'd12, 5'd24, 5'd24, 5'd12, 5'd6,  5'd3
    };

    // charlieplex pin levels per sensor led
    localparam logic [LED_W-1:0] LED_LVL_OF_SENSOR [16] = '{
        5'd16, 5'd2, 5'd8, 5'd1,  5'd4, 5'd16, 5'd4, 5'd1,
        5'd2,  5'd4, 5'd8, 5'd16, 5'd8, 5'd4,  5'd2, 5'd1
    };

endpackage

// ===== design/lsts_calib.sv =====
// gain and offset calibration of one raw reading, clamped to the output range
module lsts_calib
    import lsts_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0]     i_raw,
    input  logic [GAIN_W-1:0]          i_gain,
    input  logic signed [OFFSET_W-1:0] i_offset,
    output logic [VALUE_W-1:0]         o_value
);

    localparam int PROD_W = SAMPLE_BITS + GAIN_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic signed [SUM_W-1:0] CLAMP_HI = SUM_W'(VALUE_MAX * (1 << FRAC_W));

    logic [PROD_W-1:0]       w_prod;
    logic signed [SUM_W-1:0] w_offset_q8;
    logic signed [SUM_W-1:0] w_sum;

    // raw times gain in q.8, plus offset scaled into q.8
    assign w_prod      = PROD_W'(i_raw) * PROD_W'(i_gain);
    assign w_offset_q8 = SUM_W'(i_offset) <<< FRAC_W;
    assign w_sum       = $signed({2'b00, w_prod}) + w_offset_q8;

    // clamp to 0..max then drop the fraction
    always_comb begin
        if (w_sum < 0) begin
            o_value = '0;
        end else if (w_sum > CLAMP_HI) begin
            o_value = VALUE_W'(VALUE_MAX);
        end else begin
            o_value = w_sum[FRAC_W +: VALUE_W];
        end
    end

endmodule

// ===== design/line_sensor_threshold_scanner.sv =====
// top level of the line sensor threshold scanner
//
// Input channel: one beat per item (cmd, channel, raw_sample, gain_in, offset_in),
// taken when i_in_valid is high and o_in_stall is low. A sample beat calibrates
// the reading with the sensor's gain and offset, clamps it to 0..1023 and updates
// the sensor's on-line flag with hysteresis; a load beat writes the sensor's gain
// and offset. Channels at or above NUM_SENSORS change nothing.
// Output channel: exactly one result beat per item, taken when o_out_valid is
// high and i_out_stall is low.
// Configuration: thresholds are written through i_cfg_valid/o_cfg_ready (always
// ready), index 0 up threshold, index 1 down threshold; the user must write them
// only while idle, which the block does not enforce. An item passes the input
// register, then the result register; throughput is one item per cycle while
// the output is not stalled, with one multiply, clamp and compare between them.
// A stall on the output holds the result register; the input register keeps the
// next item and o_in_stall rises only when both are full.
// Synchronous reset sets gains to 1.0, offsets to 0, all flags to 0 and both
// thresholds to 500; no clearing sequence is needed.
module line_sensor_threshold_scanner
    import lsts_pkg::*;
#(
    parameter int NUM_SENSORS = NUM_SENSORS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input item channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_cmd,
    input  logic [CHAN_W-1:0]          i_channel,
    input  logic [SAMPLE_BITS-1:0]     i_raw_sample,
    input  logic [GAIN_W-1:0]          i_gain_in,
    input  logic signed [OFFSET_W-1:0] i_offset_in,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [CHAN_W-1:0]          o_sensor_id,
    output logic [VALUE_W-1:0]         o_calibrated_value,
    output logic                       o_on_line,
    output logic [MAP_W-1:0]           o_line_bitmap,
    output logic [MUX_W-1:0]           o_analog_channel,
    output logic [LED_W-1:0]           o_led_pin_enable,
    output logic [LED_W-1:0]           o_led_pin_level,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [VALUE_W-1:0]         i_cfg_data
);

    localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    // configuration registers
    logic [VALUE_W-1:0] r_thresh_up;
    logic [VALUE_W-1:0] r_thresh_down;

    // calibration tables and flags
    logic [GAIN_W-1:0]          r_gain_tab [NUM_SENSORS];
    logic signed [OFFSET_W-1:0] r_off_tab  [NUM_SENSORS];
    logic [MAP_W-1:0]           r_flags;
    logic [MAP_W-1:0]           n_flags;

    // input register
    logic                       r_s1_valid;
    t_cmd                       r_s1_cmd;
    logic [CHAN_W-1:0]          r_s1_chan;
    logic [SAMPLE_BITS-1:0]     r_s1_raw;
    logic [GAIN_W-1:0]          r_s1_gain;
    logic signed [OFFSET_W-1:0] r_s1_off;

    // result register
    logic               r_out_valid;
    logic [CHAN_W-1:0]  r_out_id;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_flag;
    logic [MUX_W-1:0]   r_out_mux;
    logic [LED_W-1:0]   r_out_en;
    logic [LED_W-1:0]   r_out_lvl;

    logic               w_s1_go;
    logic               w_in_take;
    logic               w_in_range;
    logic [IDX_W-1:0]   w_idx;
    logic [VALUE_W-1:0] w_cal;
    logic               w_cur_flag;
    logic               w_new_flag;
    logic [VALUE_W-1:0] n_out_value;
    logic               n_out_flag;
    logic [MUX_W-1:0]   n_out_mux;
    logic [LED_W-1:0]   n_out_en;
    logic [LED_W-1:0]   n_out_lvl;

    // handshake: stage 1 moves when the result register is empty or drains
    assign w_s1_go    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_s1_go;
    assign w_in_take  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh_up   <= THRESH_RESET;
            r_thresh_down <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_THRESH_UP:   r_thresh_up   <= i_cfg_data;
                CFG_THRESH_DOWN: r_thresh_down <= i_cfg_data;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_take) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_cmd  <= t_cmd'(i_cmd);
            r_s1_chan <= i_channel;
            r_s1_raw  <= i_raw_sample;
            r_s1_gain <= i_gain_in;
            r_s1_off  <= i_offset_in;
        end
    end

    // table lookup for the held item
    assign w_in_range = ({1'b0, r_s1_chan} < (CHAN_W + 1)'(NUM_SENSORS));
    assign w_idx      = r_s1_chan[IDX_W-1:0];
    assign w_cur_flag = r_flags[r_s1_chan];

    lsts_calib #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_calib (
        .i_raw    (r_s1_raw),
        .i_gain   (r_gain_tab[w_idx]),
        .i_offset (r_off_tab[w_idx]),
        .o_value  (w_cal)
    );

    // hysteresis: set test first, then clear test, else hold
    always_comb begin
        priority if (w_cal >= r_thresh_up) begin
            w_new_flag = 1'b1;
        end else if (w_cal < r_thresh_down) begin
            w_new_flag = 1'b0;
        end else begin
            w_new_flag = w_cur_flag;
        end
    end

    // result fields and next flag map
    always_comb begin
        n_flags     = r_flags;
        n_out_value = '0;
        n_out_flag  = 1'b0;
        n_out_mux   = '0;
        n_out_en    = '0;
        n_out_lvl   = '0;
        if (w_in_range) begin
            unique case (r_s1_cmd)
                CMD_LOAD: begin
                    n_out_flag = w_cur_flag;
                end
                CMD_SAMPLE: begin
                    n_out_value       = w_cal;
                    n_out_flag        = w_new_flag;
                    n_flags[r_s1_chan] = w_new_flag;
                    n_out_mux         = MUX_OF_SENSOR[r_s1_chan];
                    if (w_new_flag) begin
                        n_out_en  = LED_EN_OF_SENSOR[r_s1_chan];
                        n_out_lvl = LED_LVL_OF_SENSOR[r_s1_chan];
                    end
                end
            endcase
        end
    end

    // state update as the item leaves stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                r_gain_tab[i] <= GAIN_ONE;
                r_off_tab[i]  <= '0;
            end
        end else if (w_s1_go) begin
            r_flags <= n_flags;
            if (w_in_range && (r_s1_cmd == CMD_LOAD)) begin
                r_gain_tab[w_idx] <= r_s1_gain;
                r_off_tab[w_idx]  <= r_s1_off;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go) begin
            r_out_id    <= r_s1_chan;
            r_out_value <= n_out_value;
            r_out_flag  <= n_out_flag;
            r_out_mux   <= n_out_mux;
            r_out_en    <= n_out_en;
            r_out_lvl   <= n_out_lvl;
        end
    end

    // the bitmap in a result beat is the map right after its item
    logic [MAP_W-1:0] r_out_map;
    always_ff @(posedge i_clk) begin
        if (w_s1_go) begin
            r_out_map <= n_flags;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_sensor_id        = r_out_id;
    assign o_calibrated_value = r_out_value;
    assign o_on_line          = r_out_flag;
    assign o_line_bitmap      = r_out_map;
    assign o_analog_channel   = r_out_mux;
    assign o_led_pin_enable   = r_out_en;
    assign o_led_pin_level    = r_out_lvl;

endmodule

// ===== verif/lsts_scan_checker.sv =====
// result checker for the line sensor scanner: mirrors calibration and flag state, checks beats
module lsts_scan_checker
    import lsts_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input item channel
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_cmd,
    input  logic [CHAN_W-1:0]          i_channel,
    input  logic [SAMPLE_BITS_DEF-1:0] i_raw_sample,
    input  logic [GAIN_W-1:0]          i_gain_in,
    input  logic signed [OFFSET_W-1:0] i_offset_in,
    // result channel
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [CHAN_W-1:0]          i_sensor_id,
    input  logic [VALUE_W-1:0]         i_calibrated_value,
    input  logic                       i_on_line,
    input  logic [MAP_W-1:0]           i_line_bitmap,
    input  logic [MUX_W-1:0]           i_analog_channel,
    input  logic [LED_W-1:0]           i_led_pin_enable,
    input  logic [LED_W-1:0]           i_led_pin_level,
    // configuration write channel
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [VALUE_W-1:0]         i_cfg_data,
    // status toward the test top
    output int                         o_mismatch_count,
    output int                         o_results_pending
);

    // one result beat as the scanner should produce it
    typedef struct packed {
        logic [CHAN_W-1:0]  sensor_id;
        logic [VALUE_W-1:0] value;
        logic               on_line;
        logic [MAP_W-1:0]   bitmap;
        logic [MUX_W-1:0]   mux;
        logic [LED_W-1:0]   led_en;
        logic [LED_W-1:0]   led_lvl;
    } t_scan_result;

    // mirrored scanner state
    logic [VALUE_W-1:0]         thresh_up;
    logic [VALUE_W-1:0]         thresh_down;
    logic [GAIN_W-1:0]          gain_of [16];
    logic signed [OFFSET_W-1:0] offset_of [16];
    logic [MAP_W-1:0]           flags;

    t_scan_result pending_results [$];
    int           mismatch_count = 0;

    // apply one item to the mirrored state and return the beat it should cause
    function automatic t_scan_result scan_sensor(t_cmd cmd, logic [CHAN_W-1:0] chan,
            logic [SAMPLE_BITS_DEF-1:0] raw, logic [GAIN_W-1:0] gain,
            logic signed [OFFSET_W-1:0] offs);
        t_scan_result r;
        int           scaled;
        int           bias;
        logic         flag;
        r = '0;
        r.sensor_id = chan;
        if (chan < NUM_SENSORS_DEF) begin
            flag = flags[chan];
            if (cmd == CMD_LOAD) begin
                gain_of[chan]   = gain;
                offset_of[chan] = offs;
            end else begin
                // exact q.8 sum, clamped, then truncated
                bias   = offset_of[chan];
                scaled = int'(raw) * int'(gain_of[chan]) + bias * 256;
                if (scaled < 0) scaled = 0;
                if (scaled > VALUE_MAX * 256) scaled = VALUE_MAX * 256;
                r.value = VALUE_W'(scaled >>> FRAC_W);
                // set test wins over clear test
                if (r.value >= thresh_up) flag = 1'b1;
                else if (r.value < thresh_down) flag = 1'b0;
                flags[chan] = flag;
                r.mux = MUX_OF_SENSOR[chan];
                if (flag) begin
                    r.led_en  = LED_EN_OF_SENSOR[chan];
                    r.led_lvl = LED_LVL_OF_SENSOR[chan];
                end
            end
            r.on_line = flag;
        end
        r.bitmap = flags;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [CHAN_W-1:0] id, logic [MAP_W-1:0] got,
            logic [MAP_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("sensor %0d %s: got %0h expected %0h",
                                      id, name, got, want));
    endtask

    // watch all three channels at every edge
    always @(posedge i_clk) begin
        t_scan_result want;
        if (!i_rst_n) begin
            thresh_up   = THRESH_RESET;
            thresh_down = THRESH_RESET;
            for (int i = 0; i < 16; i++) begin
                gain_of[i]   = GAIN_ONE;
                offset_of[i] = '0;
            end
            flags = '0;
            pending_results.delete();
        end else begin
            // result beat against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result beat for sensor %0d with nothing pending",
                                              i_sensor_id));
                end else begin
                    want = pending_results.pop_front();
                    check_field("sensor_id", want.sensor_id, MAP_W'(i_sensor_id),
                                MAP_W'(want.sensor_id));
                    check_field("calibrated_value", want.sensor_id,
                                MAP_W'(i_calibrated_value), MAP_W'(want.value));
                    check_field("on_line", want.sensor_id, MAP_W'(i_on_line),
                                MAP_W'(want.on_line));
                    check_field("line_bitmap", want.sensor_id, i_line_bitmap, want.bitmap);
                    check_field("analog_channel", want.sensor_id, MAP_W'(i_analog_channel),
                                MAP_W'(want.mux));
                    check_field("led_pin_enable", want.sensor_id, MAP_W'(i_led_pin_enable),
                                MAP_W'(want.led_en));
                    check_field("led_pin_level", want.sensor_id, MAP_W'(i_led_pin_level),
                                MAP_W'(want.led_lvl));
                end
            end
            // threshold writes
            if (i_cfg_valid && i_cfg_ready) begin
                if (t_cfg_idx'(i_cfg_index) == CFG_THRESH_UP) thresh_up = i_cfg_data;
                else thresh_down = i_cfg_data;
            end
            // input beat
            if (i_in_valid && !i_in_stall)
                pending_results.push_back(scan_sensor(t_cmd'(i_cmd), i_channel, i_raw_sample,
                                                      i_gain_in, i_offset_in));
        end
        o_results_pending <= pending_results.size();
        o_mismatch_count  <= mismatch_count;
    end

endmodule

// ===== verif/line_sensor_threshold_scanner_test.sv =====
// test top for the line sensor scanner: drives items, thresholds and output stalls
module line_sensor_threshold_scanner_test;
    import lsts_pkg::*;

    localparam int ITEMS_PER_SETTING = 90;
    localparam int DRAIN_CYCLES      = 8;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_cmd = CMD_SAMPLE;
    logic [CHAN_W-1:0]          i_channel = '0;
    logic [SAMPLE_BITS_DEF-1:0] i_raw_sample = '0;
    logic [GAIN_W-1:0]          i_gain_in = '0;
    logic signed [OFFSET_W-1:0] i_offset_in = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [CHAN_W-1:0]          o_sensor_id;
    logic [VALUE_W-1:0]         o_calibrated_value;
    logic                       o_on_line;
    logic [MAP_W-1:0]           o_line_bitmap;
    logic [MUX_W-1:0]           o_analog_channel;
    logic [LED_W-1:0]           o_led_pin_enable;
    logic [LED_W-1:0]           o_led_pin_level;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [VALUE_W-1:0]         i_cfg_data = '0;

    int mismatch_count;
    int results_pending;
    bit steady = 1'b0;

    // threshold settings for the random phases, extremes first
    logic [VALUE_W-1:0] up_setting   [8] = '{10'd0, 10'd1023, 10'd0, 10'd1023,
                                            10'd600, 10'd200, 10'd0, 10'd0};
    logic [VALUE_W-1:0] down_setting [8] = '{10'd0, 10'd1023, 10'd1023, 10'd0,
                                            10'd400, 10'd800, 10'd0, 10'd0};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    line_sensor_threshold_scanner u_top (.*);

    lsts_scan_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_cmd              (i_cmd),
        .i_channel          (i_channel),
        .i_raw_sample       (i_raw_sample),
        .i_gain_in          (i_gain_in),
        .i_offset_in        (i_offset_in),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_sensor_id        (o_sensor_id),
        .i_calibrated_value (o_calibrated_value),
        .i_on_line          (o_on_line),
        .i_line_bitmap      (o_line_bitmap),
        .i_analog_channel   (o_analog_channel),
        .i_led_pin_enable   (o_led_pin_enable),
        .i_led_pin_level    (o_led_pin_level),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_mismatch_count   (mismatch_count),
        .o_results_pending  (results_pending)
    );

    // one input beat, after a random gap unless in a steady phase
    task automatic send_item(t_cmd cmd, logic [CHAN_W-1:0] chan,
            logic [SAMPLE_BITS_DEF-1:0] raw, logic [GAIN_W-1:0] gain,
            logic signed [OFFSET_W-1:0] offs);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_channel    <= chan;
        i_raw_sample <= raw;
        i_gain_in    <= gain;
        i_offset_in  <= offs;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // sample beat, calibration fields are don't-care
    task automatic read_sensor(logic [CHAN_W-1:0] chan, logic [SAMPLE_BITS_DEF-1:0] raw);
        send_item(CMD_SAMPLE, chan, raw, GAIN_W'($urandom), OFFSET_W'($urandom));
    endtask

    // load beat, raw reading is don't-care
    task automatic load_cal(logic [CHAN_W-1:0] chan, logic [GAIN_W-1:0] gain,
            logic signed [OFFSET_W-1:0] offs);
        send_item(CMD_LOAD, chan, SAMPLE_BITS_DEF'($urandom), gain, offs);
    endtask

    // mostly samples, loads near unity gain with an occasional wild one
    task automatic random_item();
        logic [GAIN_W-1:0]          gain;
        logic signed [OFFSET_W-1:0] offs;
        int                         bias;
        if ($urandom_range(0, 6) == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                gain = GAIN_W'($urandom_range(0, 1023));
                offs = OFFSET_W'($urandom_range(0, 2047));
            end else begin
                gain = GAIN_W'($urandom_range(128, 512));
                bias = $urandom_range(0, 400);
                offs = OFFSET_W'(bias - 200);
            end
            load_cal(CHAN_W'($urandom_range(0, 15)), gain, offs);
        end else begin
            read_sensor(CHAN_W'($urandom_range(0, 15)),
                        SAMPLE_BITS_DEF'($urandom_range(0, (1 << SAMPLE_BITS_DEF) - 1)));
        end
    endtask

    // wait until every result is back and the pipe is empty
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [VALUE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_thresholds(logic [VALUE_W-1:0] up, logic [VALUE_W-1:0] down);
        write_reg(CFG_THRESH_UP, up);
        write_reg(CFG_THRESH_DOWN, down);
        i_cfg_valid <= 1'b0;
    endtask

    // result side: random stall before each beat, none in a steady phase
    initial begin
        int hold;
        forever begin
            hold = steady ? 0 : $urandom_range(0, 15);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // stimulus and verdict
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset calibration: unity gain, zero offset, both thresholds at 500
        read_sensor(0, 0);
        read_sensor(0, 1023);
        read_sensor(0, 499);
        read_sensor(15, 500);
        // calibration extremes, clamping and truncation
        load_cal(3, 1023, 1023);
        read_sensor(3, 1023);
        load_cal(4, 0, -1024);
        read_sensor(4, 1023);
        load_cal(7, 1, 0);
        read_sensor(7, 1023);
        load_cal(9, 256, -1);
        read_sensor(9, 0);
        load_cal(5, 512, -100);
        read_sensor(5, 300);
        // load on a sensor whose flag is set
        load_cal(15, 256, 0);
        settle();

        // hysteresis band: between down and up the flag holds
        set_thresholds(600, 400);
        read_sensor(1, 500);
        read_sensor(1, 600);
        read_sensor(1, 500);
        read_sensor(1, 399);
        settle();

        // crossed thresholds: the set test wins
        set_thresholds(300, 700);
        read_sensor(2, 500);
        read_sensor(2, 650);
        read_sensor(2, 200);
        settle();

        // random phases over several threshold settings
        for (int p = 0; p < 8; p++) begin
            if (p >= 6) begin
                up_setting[p]   = VALUE_W'($urandom_range(0, 1023));
                down_setting[p] = VALUE_W'($urandom_range(0, 1023));
            end
            steady = (p % 3 == 1);
            set_thresholds(up_setting[p], down_setting[p]);
            for (int n = 0; n < ITEMS_PER_SETTING; n++) random_item();
            settle();
        end

        if (mismatch_count == 0) begin
            $display("line_sensor_threshold_scanner test passed");
        end else begin
            $display("line_sensor_threshold_scanner test failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        #3000000;
        $display("line_sensor_threshold_scanner test failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/lsts_pkg.sv
design/lsts_calib.sv
design/line_sensor_threshold_scanner.sv
verif/lsts_scan_checker.sv
verif/line_sensor_threshold_scanner_test.sv
